FILE: sv/fpa_pkg.sv
// shared types, constants and helpers of the signed q24.8 fixed-point alu
// no dependencies; used by the alu top level and its port checker
package fpa_pkg;

  // fixed-point format and datapath widths
  localparam int FRAC_BITS  = 8;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS  = NUM_W;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // pipeline stage indexes
  localparam int MUL_RND_K = 3;
  localparam int LAST_K    = DIV_STEPS + 3;

  // operation codes
  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_INC     = 4'd4,
    CMD_DEC     = 4'd5,
    CMD_COMPARE = 4'd6,
    CMD_MIN     = 4'd7,
    CMD_MAX     = 4'd8,
    CMD_TO_INT  = 4'd9
  } cmd_t;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVF  = 2'd1;
  localparam logic [1:0] STATUS_DIVZ = 2'd2;

  // per-stage sideband that travels with each word
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [1:0]  status;
    logic        dneg;
    logic        dzero;
  } side_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // apply sign to a magnitude and clamp to 32 signed bits
  function automatic sat_t sat_mag(input logic [PROD_W-1:0] mag, input logic neg);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > PROD_W'(64'h8000_0000)) begin
        s.res = 32'h8000_0000;
        s.ovf = 1'b1;
      end else begin
        s.res = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > PROD_W'(64'h7FFF_FFFF)) begin
        s.res = 32'h7FFF_FFFF;
        s.ovf = 1'b1;
      end else begin
        s.res = mag[31:0];
      end
    end
    return s;
  endfunction

  // clamp a 33-bit signed sum to 32 bits
  function automatic sat_t sat33(input logic [32:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.res = v[31:0];
    if (v[32] != v[31]) begin
      s.ovf = 1'b1;
      s.res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s;
  endfunction

endpackage

FILE: sv/fixed_point_alu_q24_8.sv
// top level of the signed q24.8 fixed-point alu: input stage, operation stage,
// multiplier rounding, restoring divider pipeline, output register and skid; uses fpa_pkg

// Signed Q24.8 arithmetic unit on a stream interface. Each input word carries an
// opcode and two raw 32-bit operands; each produces exactly one result word with
// the raw result, compare flags and a status (ok, saturated, divide by zero).
// The unit takes one word every cycle while in_tready is high. Results of all
// opcodes pass through the full Q24.8 pipeline depth alike. That depth is
// set by the divider, a restoring pipeline that resolves one quotient bit per
// stage over 32 + FRAC_BITS stages, followed by a rounding and a clamping stage.
// Product and quotient round half away from zero and saturate on overflow.
// A two-entry output buffer keeps in_tready a plain register: it drops only while
// a result waits behind an unread one, and rises again once the sink takes it.
module fixed_point_alu_q24_8 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // cmd[3:0], operand_a[35:4], operand_b[67:36], zero fill[71:68]
  input  logic [fpa_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result[31:0], less[32], equal[33], greater[34], status[36:35], zero fill[39:37]
  output logic [fpa_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int LAST = fpa_pkg::LAST_K;
  localparam int NW   = fpa_pkg::NUM_W;
  localparam int DS   = fpa_pkg::DIV_STEPS;
  localparam int PW   = fpa_pkg::PROD_W;

  logic adv;
  logic vld_r [0:LAST];

  // input stage
  fpa_pkg::cmd_t      cmd_r;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;

  // operation stage
  fpa_pkg::side_t     side_r   [1:LAST];
  fpa_pkg::side_t     side_nxt [1:LAST];
  logic signed [PW-1:0] p_r;
  logic signed [PW-1:0] p_nxt;
  logic [31:0]        amag;
  logic [31:0]        bmag;

  // multiplier rounding
  logic [PW-1:0] pmag_r;
  logic          pneg_r;

  // divider
  logic [31:0]   rem_r [0:DS];
  logic [NW-1:0] qn_r  [0:DS];
  logic [31:0]   den_r [0:DS];
  logic [NW:0]   qr_r;
  logic [NW:0]   qr_nxt;
  logic          rbit;

  // output buffer
  logic [fpa_pkg::OUT_TDATA_W-1:0] out_r;
  logic [fpa_pkg::OUT_TDATA_W-1:0] skid_r;
  logic [fpa_pkg::OUT_TDATA_W-1:0] word_nxt;
  logic                            out_vld_r;
  logic                            skid_vld_r;

  // pipeline moves whenever the skid entry is free
  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i <= LAST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r <= fpa_pkg::cmd_t'(in_tdata[3:0]);
      a_r   <= in_tdata[35:4];
      b_r   <= in_tdata[67:36];
    end
  end

  // short operations, product and divider setup
  always_comb begin
    fpa_pkg::sat_t s;
    logic [32:0]   sum33;
    side_nxt[1]        = '0;
    side_nxt[1].cmd    = cmd_r;
    side_nxt[1].status = fpa_pkg::STATUS_OK;
    side_nxt[1].dneg   = a_r[31] ^ b_r[31];
    side_nxt[1].dzero  = (b_r == 32'sd0);
    sum33 = '0;
    s     = '0;
    unique case (cmd_r)
      fpa_pkg::CMD_ADD: sum33 = {a_r[31], a_r} + {b_r[31], b_r};
      fpa_pkg::CMD_SUB: sum33 = {a_r[31], a_r} - {b_r[31], b_r};
      fpa_pkg::CMD_INC: sum33 = {a_r[31], a_r} + 33'd1;
      fpa_pkg::CMD_DEC: sum33 = {a_r[31], a_r} - 33'd1;
      default:          sum33 = '0;
    endcase
    s = fpa_pkg::sat33(sum33);
    unique case (cmd_r) inside
      fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
        side_nxt[1].res    = s.res;
        side_nxt[1].status = s.ovf ? fpa_pkg::STATUS_OVF : fpa_pkg::STATUS_OK;
      end
      fpa_pkg::CMD_COMPARE: begin
        side_nxt[1].lt = (a_r < b_r);
        side_nxt[1].eq = (a_r == b_r);
        side_nxt[1].gt = (a_r > b_r);
      end
      fpa_pkg::CMD_MIN:    side_nxt[1].res = (a_r < b_r) ? a_r : b_r;
      fpa_pkg::CMD_MAX:    side_nxt[1].res = (a_r > b_r) ? a_r : b_r;
      fpa_pkg::CMD_TO_INT: side_nxt[1].res = a_r >>> fpa_pkg::FRAC_BITS;
      default:             side_nxt[1].res = '0;
    endcase
  end

  assign p_nxt = PW'(a_r) * PW'(b_r);
  assign amag  = a_r[31] ? (32'd0 - a_r) : a_r;
  assign bmag  = b_r[31] ? (32'd0 - b_r) : b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= side_nxt[1];
      p_r       <= p_nxt;
      rem_r[0]  <= '0;
      qn_r[0]   <= {amag, fpa_pkg::FRAC_BITS'(0)};
      den_r[0]  <= bmag;
    end
  end

  // product magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      pmag_r <= p_r[PW-1] ? (PW'(0) - p_r) : p_r;
      pneg_r <= p_r[PW-1];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar d = 1; d <= DS; d++) begin : g_div
    logic [32:0] rem_ext;
    logic        ge;
    logic [32:0] rem_sub;
    assign rem_ext = {rem_r[d-1], qn_r[d-1][NW-1]};
    assign ge      = (rem_ext >= {1'b0, den_r[d-1]});
    assign rem_sub = rem_ext - {1'b0, den_r[d-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[d] <= ge ? rem_sub[31:0] : rem_ext[31:0];
        qn_r[d]  <= {qn_r[d-1][NW-2:0], ge};
        den_r[d] <= den_r[d-1];
      end
    end
  end

  // quotient rounding: add one when twice the remainder reaches the divisor
  assign rbit   = ({rem_r[DS], 1'b0} >= {1'b0, den_r[DS]});
  assign qr_nxt = {1'b0, qn_r[DS]} + (NW+1)'(rbit);

  always_ff @(posedge clk) begin
    if (adv) qr_r <= qr_nxt;
  end

  // sideband pipeline, product merged early, quotient merged last
  for (genvar k = 2; k <= LAST; k++) begin : g_side
    if (k == fpa_pkg::MUL_RND_K) begin : g_mul
      logic [PW-1:0] mround;
      fpa_pkg::sat_t sm;
      assign mround = (pmag_r + (PW'(1) << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
      assign sm     = fpa_pkg::sat_mag(mround, pneg_r);
      always_comb begin
        side_nxt[k] = side_r[k-1];
        if (side_r[k-1].cmd == fpa_pkg::CMD_MUL) begin
          side_nxt[k].res    = sm.res;
          side_nxt[k].status = sm.ovf ? fpa_pkg::STATUS_OVF : fpa_pkg::STATUS_OK;
        end
      end
    end else if (k == LAST) begin : g_quo
      fpa_pkg::sat_t sd;
      assign sd = fpa_pkg::sat_mag(PW'(qr_r), side_r[k-1].dneg);
      always_comb begin
        side_nxt[k] = side_r[k-1];
        if (side_r[k-1].cmd == fpa_pkg::CMD_DIV) begin
          if (side_r[k-1].dzero) begin
            side_nxt[k].res    = '0;
            side_nxt[k].status = fpa_pkg::STATUS_DIVZ;
          end else begin
            side_nxt[k].res    = sd.res;
            side_nxt[k].status = sd.ovf ? fpa_pkg::STATUS_OVF : fpa_pkg::STATUS_OK;
          end
        end
      end
    end else begin : g_copy
      assign side_nxt[k] = side_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) side_r[k] <= side_nxt[k];
    end
  end

  // result word packing
  assign word_nxt = {3'b000, side_r[LAST].status, side_r[LAST].gt, side_r[LAST].eq,
                     side_r[LAST].lt, side_r[LAST].res};

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= vld_r[LAST];
      out_r     <= word_nxt;
    end else if (vld_r[LAST]) begin
      skid_r     <= word_nxt;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

FILE: sv/fpa_checker.sv
// port-level checks for the fixed-point alu and the bind that attaches them
// depends on fpa_pkg and on the port list of fixed_point_alu_q24_8
module fpa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fpa_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // input is never refused while no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // at most one compare flag
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[34:32]) <= 1)
    else $error("more than one compare flag set");

  // divide by zero gives a zero result and no flags
  a_divz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[36:35] == fpa_pkg::STATUS_DIVZ
    |-> out_tdata[31:0] == 32'd0 && out_tdata[34:32] == 3'b000)
    else $error("divide by zero with nonzero result");

  // status code three and the fill bits never show
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:35] != 2'b11 && out_tdata[39:37] == 3'b000)
    else $error("bad status code or fill bits");

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: bench/fpa_alu_checker.sv
// port checker for the q24.8 fixed-point alu: predicts each result word from the
// accepted input words and compares it with the output channel; uses fpa_pkg
`timescale 1ns / 100ps

module fpa_alu_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // cmd[3:0], operand_a[35:4], operand_b[67:36], zero fill[71:68]
  input  logic [fpa_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // result[31:0], less[32], equal[33], greater[34], status[36:35], zero fill[39:37]
  input  logic [fpa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [31:0]                      fail_count,
  output logic [31:0]                      pending_count
);

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [1:0]  status;
  } alu_result_t;

  localparam longint RAW_MAX = 64'sd2147483647;
  localparam longint RAW_MIN = -64'sd2147483648;

  alu_result_t alu_results_due[$];
  alu_result_t want;
  int          mismatches = 0;
  int          due_count = 0;

  assign fail_count    = 32'(mismatches);
  assign pending_count = 32'(due_count);

  // clamp an exact signed value to 32 bits
  function automatic alu_result_t clamp_wide(input longint v);
    alu_result_t r;
    r = '0;
    if (v > RAW_MAX) begin
      r.value  = 32'h7FFF_FFFF;
      r.status = fpa_pkg::STATUS_OVF;
    end else if (v < RAW_MIN) begin
      r.value  = 32'h8000_0000;
      r.status = fpa_pkg::STATUS_OVF;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

  // give a magnitude its sign, clamping to 32 bits
  function automatic alu_result_t clamp_signed_mag(input longint unsigned mag, input bit neg);
    alu_result_t     r;
    longint unsigned negated;
    r = '0;
    negated = 64'd0 - mag;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.value  = 32'h8000_0000;
        r.status = fpa_pkg::STATUS_OVF;
      end else begin
        r.value = negated[31:0];
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.value  = 32'h7FFF_FFFF;
        r.status = fpa_pkg::STATUS_OVF;
      end else begin
        r.value = mag[31:0];
      end
    end
    return r;
  endfunction

  // exact fixed-point result of one operation
  function automatic alu_result_t compute_alu_result(input logic [3:0] op,
                                                     input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    alu_result_t     r;
    longint          wa, wb, prod;
    longint unsigned mag, num, den, quo;
    r  = '0;
    wa = longint'(a);
    wb = longint'(b);
    case (op)
      fpa_pkg::CMD_ADD: r = clamp_wide(wa + wb);
      fpa_pkg::CMD_SUB: r = clamp_wide(wa - wb);
      fpa_pkg::CMD_MUL: begin
        prod = wa * wb;
        mag  = (prod < 0) ? longint'(64'd0) - prod : prod;
        mag  = (mag + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        r    = clamp_signed_mag(mag, prod < 0);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.status = fpa_pkg::STATUS_DIVZ;
        end else begin
          num = ((wa < 0) ? -wa : wa);
          num = num << fpa_pkg::FRAC_BITS;
          den = (wb < 0) ? -wb : wb;
          // round half away from zero on the magnitude
          quo = (64'd2 * num + den) / (64'd2 * den);
          r   = clamp_signed_mag(quo, (a < 0) != (b < 0));
        end
      end
      fpa_pkg::CMD_INC: r = clamp_wide(wa + 1);
      fpa_pkg::CMD_DEC: r = clamp_wide(wa - 1);
      fpa_pkg::CMD_COMPARE: begin
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
      end
      fpa_pkg::CMD_MIN:    r.value = (a < b) ? a : b;
      fpa_pkg::CMD_MAX:    r.value = (a > b) ? a : b;
      fpa_pkg::CMD_TO_INT: r.value = a >>> fpa_pkg::FRAC_BITS;
      default:             r = '0;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // track accepted words on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        alu_results_due.push_back(compute_alu_result(in_tdata[3:0], in_tdata[35:4],
                                                     in_tdata[67:36]));
      if (out_tvalid && out_tready) begin
        if (alu_results_due.size() == 0) begin
          $display("%0t: result word with no operation pending, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = alu_results_due.pop_front();
          check_field("result", want.value, out_tdata[31:0]);
          check_field("less", 32'(want.lt), 32'(out_tdata[32]));
          check_field("equal", 32'(want.eq), 32'(out_tdata[33]));
          check_field("greater", 32'(want.gt), 32'(out_tdata[34]));
          check_field("status", 32'(want.status), 32'(out_tdata[36:35]));
        end
      end
      due_count = alu_results_due.size();
    end
  end

endmodule

FILE: bench/tb_fixed_point_alu_q24_8.sv
// testbench top for the q24.8 fixed-point alu: clock, reset, directed and random
// operations under several idle patterns, watchdog and verdict; uses fpa_pkg and fpa_alu_checker
`timescale 1ns / 100ps

module tb_fixed_point_alu_q24_8;

  localparam logic [3:0]  CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;
  localparam logic [31:0] RAW_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN  = 32'h8000_0000;
  localparam logic [31:0] RAW_LSB  = 32'h0000_0001;
  localparam logic [31:0] RAW_NEG1 = 32'hFFFF_FFFF;
  localparam logic [31:0] RAW_ONE  = 32'h0000_0100;
  localparam logic [31:0] RAW_HALF = 32'h0000_0080;
  localparam int PHASES        = 4;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [fpa_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fpa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [31:0]                     fail_count;
  logic [31:0]                     pending_count;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int idle_tab[PHASES]  = '{0, 64, 0, 25};
  int stall_tab[PHASES] = '{0, 0, 64, 25};

  fixed_point_alu_q24_8 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fpa_alu_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fixed_point_alu_q24_8 verification failed");
        $finish;
      end
    end
  end

  // offer one word, with a random gap first; returns at a falling edge
  task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= fpa_pkg::IN_TDATA_W'({b, a, op});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // operand mix: bounds, small fractional values, mid range and full range
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9)) inside
      0: begin
        case ($urandom_range(5))
          0: return 32'd0;
          1: return RAW_LSB;
          2: return RAW_NEG1;
          3: return RAW_MAX;
          4: return RAW_MIN;
          default: return RAW_ONE;
        endcase
      end
      [1:3]:   return 32'($urandom_range(8191)) - 32'd4096;
      [4:5]:   return 32'($urandom_range(2097151)) - 32'd1048576;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_word();
    logic [3:0]  op;
    logic [31:0] a, b;
    if ($urandom_range(99) < 6)
      op = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    else
      op = 4'($urandom_range(fpa_pkg::CMD_TO_INT, fpa_pkg::CMD_ADD));
    a = pick_operand();
    b = pick_operand();
    if ($urandom_range(7) == 0) b = a;
    if (op == fpa_pkg::CMD_DIV && $urandom_range(9) == 0) b = 32'd0;
    send_word(op, a, b);
  endtask

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: saturation at both bounds, rounding halves, divide by zero
    send_word(fpa_pkg::CMD_ADD, RAW_MAX, RAW_LSB);
    send_word(fpa_pkg::CMD_ADD, RAW_MIN, RAW_NEG1);
    send_word(fpa_pkg::CMD_SUB, RAW_MIN, RAW_LSB);
    send_word(fpa_pkg::CMD_SUB, RAW_MAX, RAW_NEG1);
    send_word(fpa_pkg::CMD_MUL, RAW_MAX, RAW_MAX);
    send_word(fpa_pkg::CMD_MUL, RAW_MIN, RAW_MIN);
    send_word(fpa_pkg::CMD_MUL, RAW_MIN, RAW_MAX);
    send_word(fpa_pkg::CMD_MUL, RAW_LSB, RAW_HALF);
    send_word(fpa_pkg::CMD_MUL, RAW_NEG1, RAW_HALF);
    send_word(fpa_pkg::CMD_MUL, RAW_MIN, RAW_ONE);
    send_word(fpa_pkg::CMD_DIV, RAW_ONE, 32'd0);
    send_word(fpa_pkg::CMD_DIV, RAW_MIN, RAW_NEG1);
    send_word(fpa_pkg::CMD_DIV, RAW_LSB, 32'd512);
    send_word(fpa_pkg::CMD_DIV, RAW_NEG1, 32'd512);
    send_word(fpa_pkg::CMD_DIV, RAW_MIN, RAW_MIN);
    send_word(fpa_pkg::CMD_INC, RAW_MAX, RAW_MIN);
    send_word(fpa_pkg::CMD_DEC, RAW_MIN, RAW_MAX);
    send_word(fpa_pkg::CMD_COMPARE, RAW_MIN, RAW_MIN);
    send_word(fpa_pkg::CMD_COMPARE, RAW_MIN, RAW_MAX);
    send_word(fpa_pkg::CMD_COMPARE, RAW_MAX, RAW_NEG1);
    send_word(fpa_pkg::CMD_MIN, RAW_MIN, RAW_MAX);
    send_word(fpa_pkg::CMD_MAX, RAW_MIN, RAW_MAX);
    send_word(fpa_pkg::CMD_TO_INT, RAW_NEG1, RAW_MAX);
    send_word(fpa_pkg::CMD_TO_INT, RAW_MIN, 32'd0);
    send_word(CMD_UNUSED_LO, RAW_MAX, RAW_NEG1);
    send_word(CMD_UNUSED_HI, RAW_MIN, RAW_MAX);

    // random words under each idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long sink hold-off while the source keeps offering
        if (ph == 0 && i == 30) hold_req = 1'b1;
        send_random_word();
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow for anything arriving late
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("fixed_point_alu_q24_8 verification clean");
    else
      $display("fixed_point_alu_q24_8 verification failed");
    $finish;
  end

endmodule
